// File: rtl/usls_pkg.sv
// ----------------------------------------------------------------------------
// usls_pkg: shared types and constants of the UTF-8 single-line sanitizer
// Holds the byte and code point constants, the lead byte ranges and the
// queue entry type that passes from the decode front to the output back.
// ----------------------------------------------------------------------------
package usls_pkg;

  // Default depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Lead byte ranges of multi-byte sequences.
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD4_MAX = 8'hF4;

  // Lead bytes whose second byte has a narrowed range.
  localparam logic [7:0] LEAD_E0 = 8'hE0;
  localparam logic [7:0] LEAD_ED = 8'hED;
  localparam logic [7:0] LEAD_F0 = 8'hF0;
  localparam logic [7:0] LEAD_F4 = 8'hF4;
  localparam logic [7:0] E0_SECOND_MIN = 8'hA0;
  localparam logic [7:0] ED_SECOND_MAX = 8'h9F;
  localparam logic [7:0] F0_SECOND_MIN = 8'h90;
  localparam logic [7:0] F4_SECOND_MAX = 8'h8F;

  // Code points that turn into a single space.
  localparam logic [20:0] CP_TAB = 21'h00009;
  localparam logic [20:0] CP_LF  = 21'h0000A;
  localparam logic [20:0] CP_CR  = 21'h0000D;
  localparam logic [20:0] CP_NEL = 21'h00085;
  localparam logic [20:0] CP_LS  = 21'h02028;
  localparam logic [20:0] CP_PS  = 21'h02029;

  // Control code point ranges (C0, DEL and C1).
  localparam logic [20:0] CP_C0_END   = 21'h00020;
  localparam logic [20:0] CP_DEL      = 21'h0007F;
  localparam logic [20:0] CP_C1_LAST  = 21'h0009F;

  localparam logic [7:0] SPACE_BYTE = 8'h20;

  // One queued group of results caused by one input transaction.
  // A marker entry gives one result with no byte; otherwise data[0..last_idx]
  // are sent in order.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      last_idx;
    logic            marker;
    logic            err;
    logic            eot;
  } entry_t;

endpackage

// File: rtl/utf8_single_line_sanitizer.sv
// ----------------------------------------------------------------------------
// utf8_single_line_sanitizer: strict UTF-8 decoder that flattens text to one line
//
//   Channel | Handshake          | Payload
//   --------+--------------------+--------------------------------------------
//   in_     | in_valid/in_stall  | in_byte, in_end_of_text
//   out_    | out_valid/out_stall| out_byte, out_has_byte, out_last_of_run,
//           |                    | out_text_end, out_utf8_error
//
// One input byte is taken per cycle while the queue has room; each gives zero
// to four results. The output side sends one result per cycle while out_stall
// is low, so a four-byte sequence is sent as four results in turn. An input
// byte is decoded into a queue entry, then passes through the output register.
// Reset is synchronous, active low, and clears the decoder, queue and output.
// Each side stalls on its own; the queue of QUEUE_DEPTH entries absorbs bursts.
// ----------------------------------------------------------------------------
module utf8_single_line_sanitizer #(
  parameter int QUEUE_DEPTH = usls_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_last_of_run,
  output logic       out_text_end,
  output logic       out_utf8_error
);
  import usls_pkg::*;

  logic   accept;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  entry_t push_entry;
  entry_t head;

  // An input transaction completes when the queue has room.
  assign in_stall = full;
  assign accept   = in_valid && !full;

  usls_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .push           (push),
    .push_entry     (push_entry)
  );

  usls_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  usls_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .empty           (empty),
    .pop             (pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_has_byte    (out_has_byte),
    .out_last_of_run (out_last_of_run),
    .out_text_end    (out_text_end),
    .out_utf8_error  (out_utf8_error)
  );

endmodule

// File: rtl/usls_front.sv
// ----------------------------------------------------------------------------
// usls_front: strict UTF-8 decode and classification
// Accepts one byte per transaction, tracks the pending sequence and turns
// each byte into at most one queue entry: a group of output bytes or a marker.
// ----------------------------------------------------------------------------
module usls_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            in_end_of_text,
  output logic            push,
  output usls_pkg::entry_t push_entry
);
  import usls_pkg::*;

  logic [7:0]  held0_r, held1_r, held2_r;
  logic [7:0]  held0_nxt, held1_nxt, held2_nxt;
  logic [1:0]  rem_r, rem_nxt;
  logic [1:0]  seqlen_r, seqlen_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [7:0]  lead_r, lead_nxt;
  logic        after_cr_r, after_cr_nxt;
  logic        err_hold_r, err_hold_nxt;

  logic        bad;
  logic        done;
  logic        ascii;
  logic        push_c;
  logic [20:0] cp;
  logic [1:0]  pos;
  logic        is_space_cp;
  logic        is_ctrl_cp;
  entry_t      ent;

  // Position of the continuation byte within its sequence.
  assign pos = seqlen_r - rem_r + 2'd1;

  // Classification of the finished code point.
  assign is_space_cp = (cp == CP_TAB) || (cp == CP_LF) || (cp == CP_CR) ||
                       (cp == CP_NEL) || (cp == CP_LS) || (cp == CP_PS);
  assign is_ctrl_cp  = (cp < CP_C0_END) || ((cp >= CP_DEL) && (cp <= CP_C1_LAST));

  // Decode step and entry build for the byte on the input.
  always_comb begin
    held0_nxt    = held0_r;
    held1_nxt    = held1_r;
    held2_nxt    = held2_r;
    rem_nxt      = rem_r;
    seqlen_nxt   = seqlen_r;
    acc_nxt      = acc_r;
    lead_nxt     = lead_r;
    after_cr_nxt = after_cr_r;
    err_hold_nxt = err_hold_r;
    bad          = 1'b0;
    done         = 1'b0;
    ascii        = 1'b0;
    cp           = '0;
    push_c       = 1'b0;
    ent          = '0;

    if (err_hold_r) begin
      // The rest of a broken text is dropped; its end gives one error marker.
      if (in_end_of_text) begin
        push_c       = 1'b1;
        ent.marker   = 1'b1;
        ent.err      = 1'b1;
        ent.eot      = 1'b1;
        err_hold_nxt = 1'b0;
        after_cr_nxt = 1'b0;
      end
    end else begin
      if (rem_r == 2'd0) begin
        // Lead byte.
        if (!in_byte[7]) begin
          ascii = 1'b1;
          done  = 1'b1;
          cp    = {13'd0, in_byte};
        end else if (in_byte >= LEAD2_MIN && in_byte <= LEAD2_MAX) begin
          rem_nxt = 2'd1;
          acc_nxt = {16'd0, in_byte[4:0]};
        end else if (in_byte >= LEAD3_MIN && in_byte <= LEAD3_MAX) begin
          rem_nxt = 2'd2;
          acc_nxt = {17'd0, in_byte[3:0]};
        end else if (in_byte >= LEAD4_MIN && in_byte <= LEAD4_MAX) begin
          rem_nxt = 2'd3;
          acc_nxt = {18'd0, in_byte[2:0]};
        end else begin
          bad = 1'b1;
        end
        if (!bad && !done) begin
          held0_nxt  = in_byte;
          lead_nxt   = in_byte;
          seqlen_nxt = rem_nxt;
        end
      end else begin
        // Continuation byte, with the narrowed range checked on the second byte.
        if (in_byte[7:6] != 2'b10) begin
          bad = 1'b1;
        end else if (rem_r == seqlen_r &&
                     ((lead_r == LEAD_E0 && in_byte < E0_SECOND_MIN) ||
                      (lead_r == LEAD_ED && in_byte > ED_SECOND_MAX) ||
                      (lead_r == LEAD_F0 && in_byte < F0_SECOND_MIN) ||
                      (lead_r == LEAD_F4 && in_byte > F4_SECOND_MAX))) begin
          bad = 1'b1;
        end
        if (!bad) begin
          acc_nxt = {acc_r[14:0], in_byte[5:0]};
          if (rem_r > 2'd1) begin
            if (pos == 2'd1) begin
              held1_nxt = in_byte;
            end else if (pos == 2'd2) begin
              held2_nxt = in_byte;
            end
          end
          rem_nxt = rem_r - 2'd1;
          if (rem_nxt == 2'd0) begin
            done = 1'b1;
            cp   = acc_nxt;
          end
        end
      end

      if (bad) begin
        // Error marker; the decoder starts over and the text is held off.
        push_c     = 1'b1;
        ent.marker = 1'b1;
        ent.err    = 1'b1;
        ent.eot    = in_end_of_text;
        rem_nxt    = '0;
        seqlen_nxt = '0;
        acc_nxt    = '0;
        lead_nxt   = '0;
        if (in_end_of_text) begin
          after_cr_nxt = 1'b0;
        end else begin
          err_hold_nxt = 1'b1;
        end
      end else begin
        if (done) begin
          if (is_space_cp) begin
            // LF right after CR folds into the space already sent.
            if (!(cp == CP_LF && after_cr_r)) begin
              push_c      = 1'b1;
              ent.data[0] = SPACE_BYTE;
            end
          end else if (!is_ctrl_cp) begin
            // Pass the whole sequence through: held bytes, then this byte.
            push_c       = 1'b1;
            ent.last_idx = ascii ? 2'd0 : seqlen_r;
            ent.data[0]  = ascii ? in_byte : held0_r;
            ent.data[1]  = (seqlen_r == 2'd1) ? in_byte : held1_r;
            ent.data[2]  = (seqlen_r == 2'd2) ? in_byte : held2_r;
            ent.data[3]  = in_byte;
          end
          after_cr_nxt = (cp == CP_CR);
          rem_nxt      = '0;
          seqlen_nxt   = '0;
          acc_nxt      = '0;
          lead_nxt     = '0;
        end
        if (in_end_of_text) begin
          // End of text: truncated sequence, end-only marker or end flag.
          if (rem_nxt != 2'd0) begin
            push_c       = 1'b1;
            ent.marker   = 1'b1;
            ent.err      = 1'b1;
            ent.last_idx = 2'd0;
          end else if (!push_c) begin
            push_c       = 1'b1;
            ent.marker   = 1'b1;
          end
          ent.eot      = 1'b1;
          rem_nxt      = '0;
          seqlen_nxt   = '0;
          acc_nxt      = '0;
          lead_nxt     = '0;
          after_cr_nxt = 1'b0;
          err_hold_nxt = 1'b0;
        end
      end
    end
  end

  assign push       = accept && push_c;
  assign push_entry = ent;

  // Decoder control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r      <= '0;
      seqlen_r   <= '0;
      acc_r      <= '0;
      lead_r     <= '0;
      after_cr_r <= 1'b0;
      err_hold_r <= 1'b0;
    end else if (accept) begin
      rem_r      <= rem_nxt;
      seqlen_r   <= seqlen_nxt;
      acc_r      <= acc_nxt;
      lead_r     <= lead_nxt;
      after_cr_r <= after_cr_nxt;
      err_hold_r <= err_hold_nxt;
    end
  end

  // Held bytes of the pending sequence.
  always_ff @(posedge clk) begin
    if (accept) begin
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
      held2_r <= held2_nxt;
    end
  end

  // While an error is held no sequence is pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    err_hold_r |-> (rem_r == 2'd0 && seqlen_r == 2'd0))
    else $error("usls_front: sequence pending while error is held");

  // The count of expected continuation bytes never exceeds the sequence length.
  assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= seqlen_r)
    else $error("usls_front: remaining count above sequence length");

endmodule

// File: rtl/usls_queue.sv
// ----------------------------------------------------------------------------
// usls_queue: entry queue between the decode front and the output back
// A small circular buffer of result groups, one write and one read a cycle.
// ----------------------------------------------------------------------------
module usls_queue #(
  parameter int DEPTH = usls_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  usls_pkg::entry_t push_entry,
  input  logic             pop,
  output usls_pkg::entry_t head,
  output logic             full,
  output logic             empty
);
  import usls_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t            slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full  = (count_r == CNT_FULL);
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // The front never writes into a full queue and the back never reads an empty one.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full) && !(pop && empty))
    else $error("usls_queue: overflow or underflow");

  // Pointers meet when the queue is empty or full.
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CNT_FULL) |-> (wr_ptr_r == rd_ptr_r))
    else $error("usls_queue: pointers disagree with fill count");

endmodule

// File: rtl/usls_back.sv
// ----------------------------------------------------------------------------
// usls_back: result serializer with output register
// Walks the head entry of the queue one result a cycle, while out_stall is low,
// into the output register and retires the entry with its last result.
// ----------------------------------------------------------------------------
module usls_back (
  input  logic             clk,
  input  logic             rst_n,
  input  usls_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             out_has_byte,
  output logic             out_last_of_run,
  output logic             out_text_end,
  output logic             out_utf8_error
);
  import usls_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       has_byte_r, last_r, text_end_r, err_r;
  logic       load;
  logic       take;
  logic       is_last;

  // The output register takes a new result whenever it is empty or drained.
  assign load    = !out_valid_r || !out_stall;
  assign take    = load && !empty;
  assign is_last = (idx_r == head.last_idx);
  assign pop     = take && is_last;
  assign idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= !empty;
      end
      if (take) begin
        idx_r <= idx_nxt;
      end
    end
  end

  // Result fields of the current position in the head entry.
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r     <= head.marker ? 8'd0 : head.data[idx_r];
      has_byte_r <= !head.marker;
      last_r     <= is_last;
      text_end_r <= is_last && head.eot;
      err_r      <= head.marker && head.err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = byte_r;
  assign out_has_byte    = has_byte_r;
  assign out_last_of_run = last_r;
  assign out_text_end    = text_end_r;
  assign out_utf8_error  = err_r;

  // The walk position never runs past the end of the head entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (idx_r <= head.last_idx))
    else $error("usls_back: index past end of entry");

  // A marker entry is always a single result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && head.marker) |-> (head.last_idx == 2'd0 && idx_r == 2'd0))
    else $error("usls_back: marker entry with more than one result");

endmodule
